>>> hdl/mmlp_pkg.sv
`timescale 1ns / 1ps
package mmlp_pkg;

  localparam int MAX_FILES   = 1024;
  localparam int MAX_SERVERS = 16;

  localparam int FILE_W     = 16;
  localparam int ADDR_W     = $clog2(MAX_FILES);
  localparam int COUNT_W    = $clog2(MAX_FILES + 1);
  localparam int SRV_W      = 4;
  localparam int SRV_CNT_W  = 5;
  localparam int LOAD_W     = 26;
  localparam int LIMIT_W    = 27;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [0:0]           REG_SERVER_COUNT   = 1'b0;
  localparam logic [SRV_CNT_W-1:0] SERVER_COUNT_RESET = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE_INIT,
    ST_PROBE,
    ST_DECIDE,
    ST_EMIT
  } mmlp_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [FILE_W-1:0] data;
  } mmlp_ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mmlp_ram_rd_t;

endpackage

>>> hdl/mmlp_file_if.sv
`timescale 1ns / 1ps
interface mmlp_file_if;
  import mmlp_pkg::*;

  logic              valid;
  logic              ready;
  logic [FILE_W-1:0] file_size;
  logic              last_file;

  modport source(output valid, file_size, last_file, input ready);
  modport sink(input valid, file_size, last_file, output ready);
endinterface

>>> hdl/mmlp_load_if.sv
`timescale 1ns / 1ps
interface mmlp_load_if;
  import mmlp_pkg::*;

  logic              valid;
  logic              ready;
  logic [SRV_W-1:0]  server_number;
  logic [LOAD_W-1:0] server_load;
  logic              overflow;
  logic              last_server;

  modport source(output valid, server_number, server_load, overflow, last_server, input ready);
  modport sink(input valid, server_number, server_load, overflow, last_server, output ready);
endinterface

>>> hdl/min_max_load_partition_unit.sv
`timescale 1ns / 1ps
// Min-max load partition of a file sequence over contiguous servers.
// files: one request per file size, in arrival order; last_file closes the set.
//   Sizes are taken one per cycle while the block is idle and are written
//   to a 1024-entry file RAM; files past that are dropped and flag overflow.
// After the last file the block binary-searches the load limit between 0
//   and the set total. Each probe is a greedy fill that streams the RAM:
//   a setup step, one RAM read per stored file (stops at the first misfit)
//   and a decide step; the search runs about log2(total)+1 probes, at most
//   26. The single RAM read port paces it.
// loads: one request per configured server (server_count, 1..16 via APB at
//   byte address 0; 0 acts as 1, above 16 as 16), in server order, with
//   last_server on the final one. One result leaves per cycle when taken.
// The results pass through an output register: a stalled receiver holds
//   the block in its emit phase; once the final result is registered the
//   next set of files is accepted while it still waits.
// Reset: counts, overflow and stored best loads clear, server_count = 1.
//   The file RAM is not cleared; only entries written in the set are read.
module min_max_load_partition_unit (
  input  logic                              clk,
  input  logic                              rst,
  mmlp_file_if.sink                         files,
  mmlp_load_if.source                       loads,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmlp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mmlp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mmlp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import mmlp_pkg::*;

  logic [SRV_CNT_W-1:0] server_count;
  mmlp_ram_wr_t         ram_wr;
  mmlp_ram_rd_t         ram_rd;
  logic [FILE_W-1:0]    ram_rdata;

  mmlp_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .server_count (server_count)
  );

  mmlp_file_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_rdata)
  );

  mmlp_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .server_count (server_count),
    .files        (files),
    .loads        (loads),
    .ram_wr       (ram_wr),
    .ram_rd       (ram_rd),
    .ram_rdata    (ram_rdata)
  );
endmodule

>>> hdl/mmlp_cfg.sv
`timescale 1ns / 1ps
module mmlp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmlp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mmlp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mmlp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [mmlp_pkg::SRV_CNT_W-1:0]    server_count
);
  import mmlp_pkg::*;

  logic wr_fire;
  logic sel_server_count;

  // register index sits above the byte offset
  assign sel_server_count = (paddr[CFG_ADDR_W-1] == REG_SERVER_COUNT);
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SERVER_COUNT_RESET;
    end else if (wr_fire && sel_server_count) begin
      server_count <= pwdata[SRV_CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_server_count) begin
      prdata = CFG_DATA_W'(server_count);
    end
  end
endmodule

>>> hdl/mmlp_file_ram.sv
`timescale 1ns / 1ps
module mmlp_file_ram (
  input  logic                          clk,
  input  mmlp_pkg::mmlp_ram_wr_t        wr,
  input  mmlp_pkg::mmlp_ram_rd_t        rd,
  output logic [mmlp_pkg::FILE_W-1:0]   rdata
);
  import mmlp_pkg::*;

  logic [FILE_W-1:0] mem [MAX_FILES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end
endmodule

>>> hdl/mmlp_engine.sv
`timescale 1ns / 1ps
module mmlp_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mmlp_pkg::SRV_CNT_W-1:0]   server_count,
  mmlp_file_if.sink                        files,
  mmlp_load_if.source                      loads,
  output mmlp_pkg::mmlp_ram_wr_t           ram_wr,
  output mmlp_pkg::mmlp_ram_rd_t           ram_rd,
  input  logic [mmlp_pkg::FILE_W-1:0]      ram_rdata
);
  import mmlp_pkg::*;

  mmlp_state_t state, state_next;

  logic [COUNT_W-1:0]   file_count;
  logic [COUNT_W-1:0]   proc_idx;
  logic [LOAD_W-1:0]    total_size;
  logic                 overflow_flag;
  logic [SRV_CNT_W-1:0] servers;
  logic [SRV_CNT_W-1:0] emit_idx;
  logic [LIMIT_W-1:0]   search_low;
  logic [LIMIT_W-1:0]   search_high;
  logic [LIMIT_W-1:0]   mid;
  logic [SRV_W-1:0]     srv_idx;
  logic [LOAD_W-1:0]    cur_load;
  logic                 feasible;
  logic [LOAD_W-1:0]    working_loads [MAX_SERVERS];
  logic [LOAD_W-1:0]    best_loads    [MAX_SERVERS];

  logic                 in_fire;
  logic                 store_ok;
  logic [LOAD_W-1:0]    total_next;
  logic [SRV_CNT_W-1:0] active;
  logic [LIMIT_W:0]     mid_sum;
  logic                 range_open;
  logic [COUNT_W-1:0]   proc_next;
  logic [LIMIT_W-1:0]   fit_sum;
  logic                 fits_cur;
  logic                 fits_empty;
  logic                 can_advance;
  logic                 probe_fail;
  logic                 last_proc;
  logic                 out_free;
  logic                 emit_last;

  assign in_fire    = files.valid && files.ready;
  assign store_ok   = file_count < COUNT_W'(MAX_FILES);
  assign total_next = store_ok ? total_size + LOAD_W'(files.file_size) : total_size;

  always_comb begin
    priority if (server_count == '0) begin
      active = SRV_CNT_W'(1);
    end else if (server_count > SRV_CNT_W'(MAX_SERVERS)) begin
      active = SRV_CNT_W'(MAX_SERVERS);
    end else begin
      active = server_count;
    end
  end

  assign mid_sum    = {1'b0, search_low} + {1'b0, search_high};
  assign range_open = search_low <= search_high;

  // greedy fill step: stay on this server, open the next one, or give up
  assign proc_next   = proc_idx + COUNT_W'(1);
  assign last_proc   = proc_next == file_count;
  assign fit_sum     = LIMIT_W'(ram_rdata) + LIMIT_W'(cur_load);
  assign fits_cur    = fit_sum <= mid;
  assign fits_empty  = LIMIT_W'(ram_rdata) <= mid;
  assign can_advance = (SRV_CNT_W'(srv_idx) + SRV_CNT_W'(1)) < servers;
  assign probe_fail  = !fits_cur && !(fits_empty && can_advance);

  assign out_free  = !loads.valid || loads.ready;
  assign emit_last = (emit_idx + SRV_CNT_W'(1)) == servers;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && files.last_file) state_next = ST_PROBE_INIT;
      end
      ST_PROBE_INIT: begin
        state_next = range_open ? ST_PROBE : ST_EMIT;
      end
      ST_PROBE: begin
        if (probe_fail || last_proc) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = (feasible && mid == '0) ? ST_EMIT : ST_PROBE_INIT;
      end
      ST_EMIT: begin
        if (out_free && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    files.ready  = 1'b0;
    ram_wr.en    = in_fire && store_ok;
    ram_wr.addr  = file_count[ADDR_W-1:0];
    ram_wr.data  = files.file_size;
    ram_rd.en    = 1'b0;
    ram_rd.addr  = proc_next[ADDR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        files.ready = 1'b1;
      end
      ST_PROBE_INIT: begin
        ram_rd.en   = 1'b1;
        ram_rd.addr = '0;
      end
      ST_PROBE: begin
        ram_rd.en = 1'b1;
      end
      ST_DECIDE, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      file_count    <= '0;
      total_size    <= '0;
      overflow_flag <= 1'b0;
      search_low    <= '0;
      search_high   <= '0;
      feasible      <= 1'b0;
      loads.valid   <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        best_loads[i] <= '0;
      end
    end else begin
      state <= state_next;
      // the emit phase reloads the output register itself
      if (loads.valid && loads.ready && state != ST_EMIT) loads.valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            total_size <= total_next;
            if (store_ok) begin
              file_count <= file_count + COUNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (files.last_file) begin
              servers     <= active;
              search_low  <= '0;
              search_high <= LIMIT_W'(total_next);
            end
          end
        end
        ST_PROBE_INIT: begin
          mid      <= mid_sum[LIMIT_W:1];
          cur_load <= '0;
          srv_idx  <= '0;
          proc_idx <= '0;
          feasible <= 1'b0;
          emit_idx <= '0;
          for (int i = 0; i < MAX_SERVERS; i++) begin
            working_loads[i] <= '0;
          end
        end
        ST_PROBE: begin
          proc_idx <= proc_next;
          feasible <= last_proc && !probe_fail;
          priority if (fits_cur) begin
            cur_load               <= fit_sum[LOAD_W-1:0];
            working_loads[srv_idx] <= fit_sum[LOAD_W-1:0];
          end else if (fits_empty && can_advance) begin
            srv_idx                               <= srv_idx + SRV_W'(1);
            cur_load                              <= LOAD_W'(ram_rdata);
            working_loads[srv_idx + SRV_W'(1)]    <= LOAD_W'(ram_rdata);
          end else begin
          end
        end
        ST_DECIDE: begin
          emit_idx <= '0;
          if (feasible) begin
            for (int i = 0; i < MAX_SERVERS; i++) begin
              best_loads[i] <= working_loads[i];
            end
            if (mid != '0) search_high <= mid - LIMIT_W'(1);
          end else begin
            search_low <= mid + LIMIT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            loads.valid         <= 1'b1;
            loads.server_number <= emit_idx[SRV_W-1:0];
            loads.server_load   <= best_loads[emit_idx[SRV_W-1:0]];
            loads.overflow      <= overflow_flag;
            loads.last_server   <= emit_last;
            if (emit_last) begin
              file_count    <= '0;
              total_size    <= '0;
              overflow_flag <= 1'b0;
            end else begin
              emit_idx <= emit_idx + SRV_CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

>>> hdl/mmlp_checker.sv
`timescale 1ns / 1ps
module mmlp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_last_file,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [mmlp_pkg::SRV_W-1:0]      out_server_number,
  input logic [mmlp_pkg::LOAD_W-1:0]     out_server_load,
  input logic                            out_overflow,
  input logic                            out_last_server
);
  import mmlp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_server_number)
      && $stable(out_server_load) && $stable(out_overflow) && $stable(out_last_server))
    else $error("result changed while stalled");

  // no new file is taken until the final server result is registered
  a_busy_mid_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last_server |-> !in_ready)
    else $error("file request accepted during result burst");

  a_next_server: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last_server |=> out_valid
      && out_server_number == SRV_W'($past(out_server_number) + SRV_W'(1)))
    else $error("server results out of order");

  a_overflow_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last_server |=> out_overflow == $past(out_overflow))
    else $error("overflow changed within one set");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last_file |=> !in_ready)
    else $error("intake open after last file");
endmodule

bind min_max_load_partition_unit mmlp_checker u_mmlp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (files.valid),
  .in_ready          (files.ready),
  .in_last_file      (files.last_file),
  .out_valid         (loads.valid),
  .out_ready         (loads.ready),
  .out_server_number (loads.server_number),
  .out_server_load   (loads.server_load),
  .out_overflow      (loads.overflow),
  .out_last_server   (loads.last_server)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mmlp_pkg::*;

  localparam int STALL_LIMIT = 200_000;
  localparam int RANDOM_FILES = 100;

  typedef struct packed {
    logic [SRV_W-1:0]  server_number;
    logic [LOAD_W-1:0] server_load;
    logic              overflow;
    logic              last_server;
  } server_report_t;

  // one directed request; a known load is typed in only for single-server sets
  typedef struct packed {
    logic                 cfg_wr;
    logic [SRV_CNT_W-1:0] cfg_val;
    logic [FILE_W-1:0]    size;
    logic                 last;
    logic                 known;
    logic [LOAD_W-1:0]    load;
  } file_step_t;

  localparam file_step_t DIRECTED [24] = '{
    '{1'b0, 5'd0,  16'h0000, 1'b1, 1'b1, 26'd0},
    '{1'b0, 5'd0,  16'hFFFF, 1'b1, 1'b1, 26'd65535},
    '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'h0000, 1'b1, 1'b1, 26'd131070},
    '{1'b1, 5'd0,  16'd7,    1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd9,    1'b1, 1'b1, 26'd16},
    '{1'b1, 5'd16, 16'd5,    1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd5,    1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd5,    1'b1, 1'b0, 26'd0},
    '{1'b1, 5'd31, 16'hFFFF, 1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd1,    1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'hAAAA, 1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'h5555, 1'b1, 1'b0, 26'd0},
    '{1'b1, 5'd3,  16'd10,   1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd20,   1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd30,   1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd40,   1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd50,   1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'd60,   1'b1, 1'b0, 26'd0},
    '{1'b1, 5'd17, 16'h8000, 1'b1, 1'b0, 26'd0},
    '{1'b1, 5'd2,  16'h0000, 1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b0, 26'd0},
    '{1'b0, 5'd0,  16'h0000, 1'b1, 1'b0, 26'd0}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mmlp_file_if files ();
  mmlp_load_if loads ();

  min_max_load_partition_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .files   (files),
    .loads   (loads),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // partition predictor state
  logic [FILE_W-1:0]    set_sizes[$];
  longint               set_total;
  bit                   set_dropped;
  logic [SRV_CNT_W-1:0] srv_count_cfg;
  longint               trial_loads[MAX_SERVERS];
  longint               best_fit[MAX_SERVERS];
  server_report_t       pending_loads[$];

  int fails = 0;
  int idle_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // greedy contiguous fill under a load cap
  function automatic bit greedy_fill(input longint cap, input int nsrv);
    int     s;
    longint f;
    s = 0;
    foreach (trial_loads[k]) trial_loads[k] = 0;
    foreach (set_sizes[i]) begin
      f = set_sizes[i];
      while (s < nsrv && f + trial_loads[s] > cap) s++;
      if (s >= nsrv) return 1'b0;
      trial_loads[s] += f;
    end
    return 1'b1;
  endfunction

  task automatic balance_set(input bit known, input logic [LOAD_W-1:0] known_load);
    longint lo, hi, mid;
    int     nsrv;
    nsrv = (srv_count_cfg == 0) ? 1 :
           (srv_count_cfg > MAX_SERVERS) ? MAX_SERVERS : int'(srv_count_cfg);
    lo = 0;
    hi = set_total;
    foreach (best_fit[k]) best_fit[k] = 0;
    while (lo <= hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (greedy_fill(mid, nsrv)) begin
        best_fit = trial_loads;
        if (mid == 0) break;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    if (known) begin
      pending_loads.push_back('{'0, known_load, 1'b0, 1'b1});
    end else begin
      for (int s = 0; s < nsrv; s++)
        pending_loads.push_back('{SRV_W'(s), LOAD_W'(best_fit[s]), set_dropped,
                                  s == nsrv - 1});
    end
    set_sizes.delete();
    set_total = 0;
    set_dropped = 1'b0;
  endtask

  task automatic absorb_file(input logic [FILE_W-1:0] size, input logic last,
                             input bit known, input logic [LOAD_W-1:0] known_load);
    if (set_sizes.size() < MAX_FILES) begin
      set_sizes.push_back(size);
      set_total += size;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) balance_set(known, known_load);
  endtask

  task automatic send_file(input logic [FILE_W-1:0] size, input logic last,
                           input bit known, input logic [LOAD_W-1:0] known_load);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      files.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    files.valid     <= 1'b1;
    files.file_size <= size;
    files.last_file <= last;
    do @(posedge clk); while (!files.ready);
    absorb_file(size, last, known, known_load);
  endtask

  // hold off until every load is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    files.valid <= 1'b0;
    while (pending_loads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_server_count(input logic [SRV_CNT_W-1:0] cnt);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SERVER_COUNT, 2'b00};
    pwdata  <= {27'($urandom), cnt};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    srv_count_cfg = cnt;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [FILE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return FILE_W'($urandom);
      4, 5, 6:    return FILE_W'($urandom_range(0, 15));
      7:          return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default:    return FILE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [SRV_CNT_W-1:0] pick_servers();
    if ($urandom_range(0, 1) != 0) return SRV_CNT_W'($urandom_range(1, MAX_SERVERS));
    return SRV_CNT_W'($urandom_range(0, 31));
  endfunction

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 18);
    loads.ready <= (stall_left == 0);
  end

  always @(posedge clk) begin : check_loads
    server_report_t want;
    if (!rst && loads.valid && loads.ready) begin
      if (pending_loads.size() == 0) begin
        $error("unexpected load request: server_number %0d server_load %0d",
               loads.server_number, loads.server_load);
        fails++;
      end else begin
        want = pending_loads.pop_front();
        if (loads.server_number !== want.server_number) begin
          $error("server_number: expected %0d, got %0d", want.server_number,
                 loads.server_number);
          fails++;
        end
        if (loads.server_load !== want.server_load) begin
          $error("server_load: expected %0d, got %0d", want.server_load,
                 loads.server_load);
          fails++;
        end
        if (loads.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, loads.overflow);
          fails++;
        end
        if (loads.last_server !== want.last_server) begin
          $error("last_server: expected %0b, got %0b", want.last_server,
                 loads.last_server);
          fails++;
        end
      end
    end
  end

  // a big set can keep the search busy with no handshake on either port
  always @(posedge clk) begin
    if (rst || (files.valid && files.ready) || (loads.valid && loads.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("min_max_load_partition_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    bit paused;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    files.valid     = 1'b0;
    files.file_size = '0;
    files.last_file = 1'b0;
    set_total       = 0;
    set_dropped     = 1'b0;
    srv_count_cfg   = SERVER_COUNT_RESET;
    sent            = 0;
    paused          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg_wr) begin
        settle();
        write_server_count(DIRECTED[i].cfg_val);
      end
      send_file(DIRECTED[i].size, DIRECTED[i].last, DIRECTED[i].known, DIRECTED[i].load);
    end

    // store full: the tail of the set, last file included, is dropped
    settle();
    write_server_count(5'd4);
    for (int k = 0; k < MAX_FILES + 2; k++)
      send_file(FILE_W'($urandom), k == MAX_FILES + 1, 1'b0, '0);

    while (sent < RANDOM_FILES) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        write_server_count(pick_servers());
      end else if (sent > 40 && !paused) begin
        settle();
        paused = 1'b1;
      end
      if (sent >= RANDOM_FILES - 25) idle_pct = 0;
      else idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        send_file(pick_size(), k == len - 1, 1'b0, '0);
        sent++;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (pending_loads.size() != 0) begin
      $error("%0d load requests never arrived", pending_loads.size());
      fails++;
    end
    if (fails == 0) begin
      $display("min_max_load_partition_unit verification clean");
    end else begin
      $display("min_max_load_partition_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/mmlp_pkg.sv
hdl/mmlp_file_if.sv
hdl/mmlp_load_if.sv
hdl/mmlp_cfg.sv
hdl/mmlp_file_ram.sv
hdl/mmlp_engine.sv
hdl/min_max_load_partition_unit.sv
hdl/mmlp_checker.sv
tb/tb_top.sv
